// ===== rtl/dtq_pkg.sv =====
`default_nettype none

package dtq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic CMD_QUEUE = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_DESC   = 1'b1;

   localparam logic [1:0] STATUS_ADDED = 2'd0;
   localparam logic [1:0] STATUS_DUP   = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic        command;
      logic [31:0] source_address;
      logic [31:0] dest_address;
      logic [31:0] byte_count;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic        entry_valid;
      logic [31:0] out_source;
      logic [31:0] out_dest;
      logic [31:0] out_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] src;
      logic [31:0] dst;
      logic [31:0] cnt;
   } entry_type;

   // per-cell control from the queue controller
   typedef struct packed {
      logic live;
      logic load;
      logic shift;
   } cell_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/dtq_cell.sv =====
`default_nettype none

module dtq_cell (
   input  wire logic                 clock,
   input  wire dtq_pkg::cell_ctl_type ctl,
   input  wire dtq_pkg::entry_type   new_entry,
   input  wire dtq_pkg::entry_type   next_entry,
   output dtq_pkg::entry_type        entry,
   output logic                      match
);
   import dtq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.load) begin
         entry_in = new_entry;
      end else if (ctl.shift) begin
         entry_in = next_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   // only occupied cells take part in the duplicate check
   assign match = ctl.live && (entry_ff.src == new_entry.src)
                  && (entry_ff.dst == new_entry.dst);

endmodule

`default_nettype wire

// ===== rtl/dedup_transfer_queue.sv =====
`default_nettype none

// Deduplicating copy-descriptor queue. A queue transfer (command 0) is checked
// against every held descriptor at once and answered with one status result
// (added, duplicate or full) in the cycle after it is taken. A flush transfer
// (command 1) drains the held descriptors oldest first, one result per cycle
// while the result side keeps up, the last of them marked as last; an empty flush
// gives a single last result with no descriptor. The descriptors sit in a row of
// cells that shift toward cell 0 during the drain. No new transfer is taken
// during a drain. The queue holds QUEUE_DEPTH descriptors; reset empties it at once.
module dedup_transfer_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire dtq_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output dtq_pkg::rsp_type      rsp_data
);
   import dtq_pkg::*;

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type          state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   entry_type          new_entry;
   entry_type          cell_entry [QUEUE_DEPTH+1];
   logic [QUEUE_DEPTH-1:0] cell_match;
   cell_ctl_type       cell_ctl [QUEUE_DEPTH];

   logic out_free, req_take, is_queue, is_flush, hit, full, add_en, drain_step;

   assign new_entry = '{src: req_data.source_address, dst: req_data.dest_address,
                        cnt: req_data.byte_count};

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE) && out_free;
   assign req_take   = req_valid && req_ready;
   assign is_queue   = req_take && (req_data.command == CMD_QUEUE);
   assign is_flush   = req_take && (req_data.command == CMD_FLUSH);
   assign hit        = |cell_match;
   assign full       = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign add_en     = is_queue && !hit && !full;
   assign drain_step = (state_ff == ST_DRAIN) && out_free;

   // past the last cell the row is fed with zeros
   assign cell_entry[QUEUE_DEPTH] = '0;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      assign cell_ctl[i].live  = (FILL_W'(i) < fill_ff);
      assign cell_ctl[i].load  = add_en && (fill_ff == FILL_W'(i));
      assign cell_ctl[i].shift = drain_step;

      dtq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .new_entry  (new_entry),
         .next_entry (cell_entry[i+1]),
         .entry      (cell_entry[i]),
         .match      (cell_match[i])
      );
   end

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (is_queue) begin
               rsp_in        = '0;
               rsp_in.kind   = KIND_STATUS;
               rsp_in.last   = 1'b1;
               rsp_in.status = hit ? STATUS_DUP : (full ? STATUS_FULL : STATUS_ADDED);
               rsp_valid_in  = 1'b1;
               if (add_en) begin
                  fill_in = fill_ff + 1'b1;
               end
            end else if (is_flush) begin
               if (fill_ff == '0) begin
                  rsp_in       = '0;
                  rsp_in.kind  = KIND_DESC;
                  rsp_in.last  = 1'b1;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            if (out_free) begin
               rsp_in.kind        = KIND_DESC;
               rsp_in.status      = STATUS_ADDED;
               rsp_in.entry_valid = 1'b1;
               rsp_in.out_source  = cell_entry[0].src;
               rsp_in.out_dest    = cell_entry[0].dst;
               rsp_in.out_count   = cell_entry[0].cnt;
               rsp_in.last        = (fill_ff == FILL_W'(1));
               rsp_valid_in       = 1'b1;
               fill_in            = fill_ff - 1'b1;
               if (fill_ff == FILL_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("fill level beyond queue depth");

   a_add_counts: assert property (@(posedge clock) disable iff (reset)
      add_en |=> fill_ff == $past(fill_ff) + 1'b1)
      else $error("added descriptor not counted");

   a_drain_end: assert property (@(posedge clock) disable iff (reset)
      (drain_step && fill_ff == FILL_W'(1)) |=>
         (state_ff == ST_IDLE) && (fill_ff == '0) && rsp_valid_ff && rsp_ff.last)
      else $error("drain did not end with an empty queue and a last result");

   a_no_take_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> !req_ready)
      else $error("transfer taken during drain");

endmodule

`default_nettype wire
